// File: hw/rtl/virtqueue_descriptor_free_list_macros.svh
// Assertion macros for the descriptor free list RTL.
// Included by vqfl_back, which carries the concurrent checks; no other dependencies.
`ifndef VIRTQUEUE_DESCRIPTOR_FREE_LIST_MACROS_SVH
`define VIRTQUEUE_DESCRIPTOR_FREE_LIST_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VQFL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vqfl check failed");

// Next-cycle implication, checked outside reset.
`define VQFL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vqfl check failed");

`endif

// File: hw/rtl/vqfl_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the descriptor free list.
// No dependencies; every other RTL file but the macros header imports this package.
package vqfl_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FRAME_W     = 16;
  localparam int LEN_W       = 11;
  localparam int PUB_W       = 16;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 9;
  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

  localparam logic [LEN_W-1:0] TX_LIMIT = LEN_W'(1536);
  localparam logic [CNT_W-1:0] MIN_FREE = CNT_W'(2);
  localparam logic [CNT_W-1:0] MIN_SIZE = CNT_W'(2);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_ENTRIES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = CFG_IDX_W'(1);

  localparam logic KIND_SEND = 1'b0;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DISABLED = 2'd1,
    ST_LOW      = 2'd2
  } status_t;

  // Classes of work that the front hands to the back.
  typedef enum logic [1:0] {
    OP_REFUSE,
    OP_SEND,
    OP_FREE,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [LEN_W-1:0] sent_length;
    logic [IDX_W-1:0] head;
  } cmd_t;

  typedef struct packed {
    logic             rebuild;
    logic [CNT_W-1:0] eff_size;
  } cfg_ctl_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] header_index;
    logic [IDX_W-1:0] payload_index;
    logic [IDX_W-1:0] ring_slot;
    logic [LEN_W-1:0] sent_length;
    logic [CNT_W-1:0] freed_count;
    logic [CNT_W-1:0] free_left;
  } result_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SEND_DAT,
    B_SEND_WR_HDR,
    B_SEND_WR_DAT,
    B_FREE_STEP
  } bstate_t;

endpackage

// File: hw/rtl/vqfl_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request words, result words, config writes.
// Depends on vqfl_pkg for field widths.
interface vqfl_req_if import vqfl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [FRAME_W-1:0] frame_length;
  logic [IDX_W-1:0]   completed_head;

  modport source(output valid, kind, frame_length, completed_head, input ready);
  modport sink(input valid, kind, frame_length, completed_head, output ready);
endinterface

interface vqfl_rsp_if import vqfl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [IDX_W-1:0] header_index;
  logic [IDX_W-1:0] payload_index;
  logic [IDX_W-1:0] ring_slot;
  logic [LEN_W-1:0] sent_length;
  logic [CNT_W-1:0] freed_count;
  logic [CNT_W-1:0] free_left;

  modport source(output valid, status, header_index, payload_index, ring_slot,
                 sent_length, freed_count, free_left, input ready);
  modport sink(input valid, status, header_index, payload_index, ring_slot,
               sent_length, freed_count, free_left, output ready);
endinterface

interface vqfl_cfg_if import vqfl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: hw/rtl/vqfl_cmd_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the classifying front and the executing back.
// Depends on vqfl_pkg for cmd_t and the queue depth.
module vqfl_cmd_fifo import vqfl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head_cmd,
  output logic empty
);

  cmd_t                  slots [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] count;

  assign full     = (count == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign empty    = (count == '0);
  assign head_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + CMDQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + CMDQ_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CMDQ_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CMDQ_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: hw/rtl/vqfl_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers and classification of request words.
// Depends on vqfl_pkg and the channel interfaces in vqfl_if.sv.
module vqfl_front import vqfl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  vqfl_req_if.sink  req,
  vqfl_cfg_if.sink  cfg,
  input  logic      fifo_full,
  output logic      push,
  output cmd_t      push_cmd,
  output cfg_ctl_t  ctl
);

  logic [CNT_W-1:0] queue_entries;
  logic             enable;
  logic             rebuild;
  logic [CNT_W-1:0] eff_size;

  assign cfg.ready = 1'b1;
  assign req.ready = !fifo_full;
  assign push      = req.valid && req.ready;

  always_comb begin
    if (queue_entries < MIN_SIZE) begin
      eff_size = MIN_SIZE;
    end else if (queue_entries > DEPTH_CNT) begin
      eff_size = DEPTH_CNT;
    end else begin
      eff_size = queue_entries;
    end
  end

  assign ctl.rebuild  = rebuild;
  assign ctl.eff_size = eff_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_entries <= DEPTH_CNT;
      enable        <= 1'b0;
      rebuild       <= 1'b0;
    end else begin
      rebuild <= cfg.valid && (cfg.index == REG_QUEUE_ENTRIES);
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_QUEUE_ENTRIES: queue_entries <= CNT_W'(cfg.data);
          REG_ENABLE:        enable        <= cfg.data[0];
          default: ;
        endcase
      end
    end
  end

  // A completion whose head lies outside the queue frees nothing.
  always_comb begin
    if (!enable) begin
      push_cmd.op = OP_REFUSE;
    end else if (req.kind == KIND_SEND) begin
      push_cmd.op = OP_SEND;
    end else if (CNT_W'(req.completed_head) < eff_size) begin
      push_cmd.op = OP_FREE;
    end else begin
      push_cmd.op = OP_NOP;
    end
    if (req.frame_length > FRAME_W'(TX_LIMIT)) begin
      push_cmd.sent_length = TX_LIMIT;
    end else begin
      push_cmd.sent_length = req.frame_length[LEN_W-1:0];
    end
    push_cmd.head = req.completed_head;
  end

endmodule

// File: hw/rtl/vqfl_back.sv
`timescale 1ns / 1ps
// Back end: descriptor link memory, free list pointers and the result register.
// Depends on vqfl_pkg, vqfl_if.sv and the assertion macros header.
`include "virtqueue_descriptor_free_list_macros.svh"

module vqfl_back import vqfl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_ctl_t  ctl,
  input  logic      cmd_empty,
  input  cmd_t      cmd,
  output logic      pop,
  vqfl_rsp_if.source rsp
);

  typedef struct packed {
    logic             more;
    logic [IDX_W-1:0] link;
  } entry_t;

  // Contents of an entry that has not been written since the last rebuild.
  function automatic entry_t dflt_entry(logic [IDX_W-1:0] a, logic [CNT_W-1:0] s);
    logic [CNT_W-1:0] n;
    entry_t           e;
    n = CNT_W'(a) + CNT_W'(1);
    if (n < s) begin
      e.more = 1'b1;
      e.link = n[IDX_W-1:0];
    end else begin
      e.more = 1'b0;
      e.link = '0;
    end
    return e;
  endfunction

  entry_t           mem [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] written;
  entry_t           rd_q;
  logic [IDX_W-1:0] rd_addr_q;
  logic             rd_written_q;
  entry_t           entry;

  bstate_t          state;
  bstate_t          state_next;
  logic [IDX_W-1:0] list_head;
  logic [CNT_W-1:0] free_total;
  logic [PUB_W-1:0] publish_index;
  logic [IDX_W-1:0] slot_count;
  logic [IDX_W-1:0] hdr_q;
  logic [IDX_W-1:0] dat_q;
  logic [IDX_W-1:0] idx_q;
  logic [CNT_W-1:0] freed_q;
  logic [LEN_W-1:0] len_q;
  result_t          res;
  logic             res_valid;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             res_load;
  result_t          res_data;
  logic             walk_more;
  logic [CNT_W-1:0] free_inc;
  logic [CNT_W-1:0] slot_inc;
  logic             start;

  assign entry    = rd_written_q ? rd_q : dflt_entry(rd_addr_q, ctl.eff_size);
  assign free_inc = free_total + CNT_W'(1);
  assign slot_inc = CNT_W'(slot_count) + CNT_W'(1);
  assign start    = !cmd_empty && !res_valid;

  // The walk stops at the end of the chain, on a link outside the queue, or
  // once every descriptor is back on the list.
  assign walk_more = entry.more && (CNT_W'(entry.link) < ctl.eff_size) &&
                     (free_inc < ctl.eff_size);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (start) begin
          if (cmd.op == OP_SEND && free_total >= MIN_FREE) begin
            state_next = B_SEND_DAT;
          end else if (cmd.op == OP_FREE && free_total < ctl.eff_size) begin
            state_next = B_FREE_STEP;
          end
        end
      end
      B_SEND_DAT:    state_next = B_SEND_WR_HDR;
      B_SEND_WR_HDR: state_next = B_SEND_WR_DAT;
      B_SEND_WR_DAT: state_next = B_IDLE;
      B_FREE_STEP:   state_next = walk_more ? B_FREE_STEP : B_IDLE;
      default:       state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    we       = 1'b0;
    wr_addr  = '0;
    wr_data  = '0;
    res_load = 1'b0;
    res_data = '0;
    res_data.status    = ST_OK;
    res_data.free_left = free_total;
    unique case (state)
      B_IDLE: begin
        if (start) begin
          pop = 1'b1;
          case (cmd.op)
            OP_REFUSE: begin
              res_load        = 1'b1;
              res_data.status = ST_DISABLED;
            end
            OP_SEND: begin
              if (free_total < MIN_FREE) begin
                res_load        = 1'b1;
                res_data.status = ST_LOW;
              end else begin
                rd_en   = 1'b1;
                rd_addr = list_head;
              end
            end
            OP_FREE: begin
              if (free_total >= ctl.eff_size) begin
                res_load = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = cmd.head;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      B_SEND_DAT: begin
        rd_en   = 1'b1;
        rd_addr = entry.link;
      end
      B_SEND_WR_HDR: begin
        we           = 1'b1;
        wr_addr      = hdr_q;
        wr_data.more = 1'b1;
        wr_data.link = dat_q;
      end
      B_SEND_WR_DAT: begin
        we                     = 1'b1;
        wr_addr                = dat_q;
        res_load               = 1'b1;
        res_data.header_index  = hdr_q;
        res_data.payload_index = dat_q;
        res_data.ring_slot     = slot_count;
        res_data.sent_length   = len_q;
      end
      B_FREE_STEP: begin
        we           = 1'b1;
        wr_addr      = idx_q;
        wr_data.more = 1'b1;
        wr_data.link = list_head;
        if (walk_more) begin
          rd_en   = 1'b1;
          rd_addr = entry.link;
        end else begin
          res_load             = 1'b1;
          res_data.freed_count = freed_q + CNT_W'(1);
          res_data.free_left   = free_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      written       <= '0;
      list_head     <= '0;
      free_total    <= DEPTH_CNT;
      publish_index <= '0;
      slot_count    <= '0;
      res_valid     <= 1'b0;
    end else if (ctl.rebuild) begin
      state         <= B_IDLE;
      written       <= '0;
      list_head     <= '0;
      free_total    <= ctl.eff_size;
      publish_index <= '0;
      slot_count    <= '0;
    end else begin
      state <= state_next;
      if (we) begin
        written[wr_addr] <= 1'b1;
      end
      if (state == B_SEND_WR_HDR) begin
        list_head  <= entry.link;
        free_total <= free_total - MIN_FREE;
      end
      if (state == B_SEND_WR_DAT) begin
        publish_index <= publish_index + PUB_W'(1);
        // The 16-bit publish index wraps to zero, which restarts the slot.
        if (publish_index == '1 || slot_inc == ctl.eff_size) begin
          slot_count <= '0;
        end else begin
          slot_count <= slot_inc[IDX_W-1:0];
        end
      end
      if (state == B_FREE_STEP) begin
        list_head  <= idx_q;
        free_total <= free_inc;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE) begin
      hdr_q   <= list_head;
      idx_q   <= cmd.head;
      freed_q <= '0;
      len_q   <= cmd.sent_length;
    end
    if (state == B_SEND_DAT) begin
      dat_q <= entry.link;
    end
    if (state == B_FREE_STEP) begin
      idx_q   <= entry.link;
      freed_q <= freed_q + CNT_W'(1);
    end
    if (res_load) begin
      res <= res_data;
    end
  end

  // Write-first forwarding covers a chain that links an entry to itself.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_addr_q <= rd_addr;
      if (we && wr_addr == rd_addr) begin
        rd_q         <= wr_data;
        rd_written_q <= 1'b1;
      end else begin
        rd_q         <= mem[rd_addr];
        rd_written_q <= written[rd_addr];
      end
    end
  end

  assign rsp.valid         = res_valid;
  assign rsp.status        = res.status;
  assign rsp.header_index  = res.header_index;
  assign rsp.payload_index = res.payload_index;
  assign rsp.ring_slot     = res.ring_slot;
  assign rsp.sent_length   = res.sent_length;
  assign rsp.freed_count   = res.freed_count;
  assign rsp.free_left     = res.free_left;

  `VQFL_ASSERT_NOW(a_free_bound, clk, rst, !ctl.rebuild, free_total <= ctl.eff_size)
  `VQFL_ASSERT_NOW(a_head_bound, clk, rst, !ctl.rebuild, CNT_W'(list_head) < ctl.eff_size)
  `VQFL_ASSERT_NOW(a_walk_room, clk, rst, state == B_FREE_STEP, free_total < ctl.eff_size)
  `VQFL_ASSERT_NEXT(a_send_take, clk, rst, state == B_SEND_WR_HDR && !ctl.rebuild,
                    free_total == $past(free_total) - MIN_FREE)

endmodule

// File: hw/rtl/virtqueue_descriptor_free_list.sv
`timescale 1ns / 1ps
// Channel    | Dir | Words
// req        | in  | kind, frame_length, completed_head
// rsp        | out | status, header_index, payload_index, ring_slot, sent_length,
//            |     | freed_count, free_left
// cfg        | in  | index 0 queue_entries, index 1 enable; always ready
//
// An accepted request word is registered in a two-entry queue, from which the back
// takes it once idle with no result pending. Refused and out-of-range words are
// answered from idle; a send reads two links and writes two entries, a completion
// returns one descriptor per walk step, since the link memory gives one read a cycle.
// Reset and a queue_entries write rebuild the free list at once through per-entry
// written bits; no clearing pass. The request side stalls only when the queue is full.
// Depends on vqfl_pkg, vqfl_if.sv, vqfl_front, vqfl_cmd_fifo and vqfl_back.
module virtqueue_descriptor_free_list import vqfl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  vqfl_req_if.sink   req,
  vqfl_rsp_if.source rsp,
  vqfl_cfg_if.sink   cfg
);

  logic     push;
  cmd_t     push_cmd;
  logic     fifo_full;
  logic     pop;
  cmd_t     head_cmd;
  logic     empty;
  cfg_ctl_t ctl;

  vqfl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .fifo_full (fifo_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .ctl       (ctl)
  );

  vqfl_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (empty)
  );

  vqfl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cmd_empty (empty),
    .cmd       (head_cmd),
    .pop       (pop),
    .rsp       (rsp)
  );

endmodule

// File: verif/vqfl_tx_checker.sv
`timescale 1ns / 1ps
// Checker for the descriptor free list: watches the request, result and config
// channels, predicts every result word and compares it field by field.
// Depends on vqfl_pkg and the channel interfaces in vqfl_if.sv.
module vqfl_tx_checker import vqfl_pkg::*; (
  input  logic clk,
  input  logic rst,
  vqfl_req_if  req,
  vqfl_rsp_if  rsp,
  vqfl_cfg_if  cfg,
  output int   mismatch_count,
  output int   words_owed
);

  localparam int MAX_PRINTED = 100;

  // Predicted descriptor table and allocator state.
  logic [IDX_W-1:0] next_desc [QUEUE_DEPTH];
  logic             more_flag [QUEUE_DEPTH];
  int unsigned      list_top;
  int unsigned      free_cnt;
  int unsigned      ring_size;
  logic [PUB_W-1:0] ring_pos;
  logic             enabled;

  result_t owed_q [$];
  result_t want;
  int      fails = 0;

  task automatic report_mismatch(string msg);
    if (fails < MAX_PRINTED) $display("%0t vqfl checker: %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(string fname, int unsigned got, int unsigned wanted);
    if (got != wanted)
      report_mismatch($sformatf("%s is %0d, expected %0d", fname, got, wanted));
  endtask

  function automatic int unsigned clamp_size(logic [CFG_DATA_W-1:0] v);
    if (v < MIN_SIZE) return 32'(MIN_SIZE);
    if (v > DEPTH_CNT) return 32'(DEPTH_CNT);
    return 32'(v);
  endfunction

  // Free list back in index order; the last descriptor in use ends the chain.
  function automatic void relink_all();
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      next_desc[i] = (i + 1 < ring_size) ? IDX_W'(i + 1) : '0;
      more_flag[i] = (i + 1 < ring_size);
    end
    list_top = 0;
    free_cnt = ring_size;
    ring_pos = '0;
  endfunction

  function automatic result_t allocate_or_reclaim(logic kind, logic [FRAME_W-1:0] len,
                                                  logic [IDX_W-1:0] head);
    result_t     r;
    int unsigned hdr;
    int unsigned dat;
    int unsigned idx;
    int unsigned nxt;
    int unsigned freed;
    logic        more;
    r        = '0;
    r.status = ST_OK;
    freed    = 0;
    if (!enabled) begin
      r.status = ST_DISABLED;
    end else if (kind == KIND_SEND) begin
      if (free_cnt < MIN_FREE) begin
        r.status = ST_LOW;
      end else begin
        hdr            = list_top % ring_size;
        dat            = next_desc[hdr] % ring_size;
        list_top       = next_desc[dat] % ring_size;
        free_cnt       = free_cnt - 2;
        next_desc[hdr] = IDX_W'(dat);
        more_flag[hdr] = 1'b1;
        next_desc[dat] = '0;
        more_flag[dat] = 1'b0;
        r.header_index  = IDX_W'(hdr);
        r.payload_index = IDX_W'(dat);
        r.sent_length   = (len > TX_LIMIT) ? TX_LIMIT : LEN_W'(len);
        r.ring_slot     = IDX_W'(ring_pos % ring_size);
        ring_pos        = ring_pos + 1'b1;
      end
    end else if (head < ring_size) begin
      // The walk stops once the list is whole again, so bogus heads cannot loop.
      idx = head;
      while (free_cnt < ring_size) begin
        more           = more_flag[idx];
        nxt            = next_desc[idx];
        next_desc[idx] = IDX_W'(list_top);
        more_flag[idx] = 1'b1;
        list_top       = idx;
        free_cnt++;
        freed++;
        if (!more || nxt >= ring_size) break;
        idx = nxt;
      end
    end
    r.freed_count = CNT_W'(freed);
    r.free_left   = CNT_W'(free_cnt);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      enabled   = 1'b0;
      ring_size = 32'(DEPTH_CNT);
      relink_all();
      owed_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_QUEUE_ENTRIES) begin
          ring_size = clamp_size(cfg.data);
          relink_all();
        end else if (cfg.index == REG_ENABLE) begin
          enabled = cfg.data[0];
        end
      end
      if (req.valid && req.ready)
        owed_q.push_back(allocate_or_reclaim(req.kind, req.frame_length,
                                             req.completed_head));
      if (rsp.valid && rsp.ready) begin
        if (owed_q.size() == 0) begin
          report_mismatch("result word with no request outstanding");
        end else begin
          want = owed_q.pop_front();
          check_field("status", rsp.status, want.status);
          check_field("header_index", rsp.header_index, want.header_index);
          check_field("payload_index", rsp.payload_index, want.payload_index);
          check_field("ring_slot", rsp.ring_slot, want.ring_slot);
          check_field("sent_length", rsp.sent_length, want.sent_length);
          check_field("freed_count", rsp.freed_count, want.freed_count);
          check_field("free_left", rsp.free_left, want.free_left);
        end
      end
    end
    words_owed     <= owed_q.size();
    mismatch_count <= fails;
  end

endmodule

// File: verif/tb_virtqueue_descriptor_free_list.sv
`timescale 1ns / 1ps
// Top of the descriptor free list testbench: clock, reset, stimulus and verdict.
// Depends on vqfl_pkg, vqfl_if.sv, the block and vqfl_tx_checker.
module tb_virtqueue_descriptor_free_list;
  import vqfl_pkg::*;

  localparam int PERIOD     = 4;
  localparam int RX_HOLD    = 300;
  localparam int QUIET_MAX  = 5000;
  localparam int PHASES     = 10;
  localparam int PHASE_LEN  = 160;
  localparam int TAIL       = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #(PERIOD / 2) clk = ~clk;

  vqfl_req_if req_ch ();
  vqfl_rsp_if rsp_ch ();
  vqfl_cfg_if cfg_ch ();

  int mismatches;
  int owed;

  virtqueue_descriptor_free_list dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  vqfl_tx_checker chk (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .cfg            (cfg_ch),
    .mismatch_count (mismatches),
    .words_owed     (owed)
  );

  logic        tx_gaps;
  logic        rx_gaps;
  logic        hold_rsp;
  int unsigned cur_size;

  // Heads of chains the block has handed out, used to build sane completions.
  logic [IDX_W-1:0] live_heads [$];
  logic             kinds_in_flight [$];

  logic             seen_req;
  logic             seen_rsp;
  logic             seen_kind;
  logic [1:0]       seen_status;
  logic [IDX_W-1:0] seen_hdr;

  always @(posedge clk) begin
    seen_req    <= req_ch.valid && req_ch.ready;
    seen_kind   <= req_ch.kind;
    seen_rsp    <= rsp_ch.valid && rsp_ch.ready;
    seen_status <= rsp_ch.status;
    seen_hdr    <= rsp_ch.header_index;
  end

  always @(negedge clk) begin
    logic k;
    if (seen_req === 1'b1) kinds_in_flight.push_back(seen_kind);
    if (seen_rsp === 1'b1 && kinds_in_flight.size() > 0) begin
      k = kinds_in_flight.pop_front();
      if (k == KIND_SEND && seen_status == ST_OK) live_heads.push_back(seen_hdr);
    end
  end

  int quiet = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet <= 0;
      end else if (quiet == QUIET_MAX) begin
        $display("tb_virtqueue_descriptor_free_list: errors");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Result side: random stalls per word, and one long hold-off on request.
  initial begin : rsp_drain
    int wait_n;
    bit hold_done;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_rsp && !hold_done) begin
        wait_n    = RX_HOLD;
        hold_done = 1'b1;
      end else begin
        wait_n = rx_gaps ? $urandom_range(0, 14) : 0;
      end
      if (wait_n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  task automatic offer(logic k, logic [FRAME_W-1:0] len, logic [IDX_W-1:0] head);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.kind           <= k;
    req_ch.frame_length   <= len;
    req_ch.completed_head <= head;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Stop offering and wait for every outstanding result word.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_QUEUE_ENTRIES) begin
      live_heads.delete();
      cur_size = (val < MIN_SIZE) ? MIN_SIZE : ((val > DEPTH_CNT) ? DEPTH_CNT : val);
    end
  endtask

  function automatic logic [FRAME_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return FRAME_W'(TX_LIMIT);
      2:       return FRAME_W'(TX_LIMIT) + 1'b1;
      3:       return '1;
      4, 5, 6: return FRAME_W'($urandom_range(0, TX_LIMIT));
      default: return FRAME_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly sends and completions of chains actually handed out; some noise.
  task automatic next_word();
    int pick;
    if ($urandom_range(0, 99) < 15) begin
      offer(1'($urandom_range(0, 1)), pick_length(), IDX_W'($urandom_range(0, 255)));
    end else if (live_heads.size() > 0 &&
                 ($urandom_range(0, 99) < 45 || live_heads.size() * 2 + 2 > cur_size)) begin
      pick = $urandom_range(0, live_heads.size() - 1);
      offer(~KIND_SEND, pick_length(), live_heads[pick]);
      live_heads.delete(pick);
    end else begin
      offer(KIND_SEND, pick_length(), IDX_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int unsigned sizes [PHASES] = '{256, 0, 64, 2, 511, 3, 17, 255, 0, 0};
    int unsigned sz;
    req_ch.valid          <= 1'b0;
    req_ch.kind           <= KIND_SEND;
    req_ch.frame_length   <= '0;
    req_ch.completed_head <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= REG_QUEUE_ENTRIES;
    cfg_ch.data           <= '0;
    rx_gaps               <= 1'b1;
    hold_rsp              <= 1'b0;
    tx_gaps  = 1'b1;
    cur_size = QUEUE_DEPTH;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: refusals while disabled, then clamping, exhaustion, bad heads.
    offer(KIND_SEND, 16'd100, '0);
    offer(~KIND_SEND, '0, '0);
    settle();
    write_reg(REG_ENABLE, 9'd1);
    offer(KIND_SEND, '0, '0);
    offer(KIND_SEND, '1, '0);
    offer(KIND_SEND, FRAME_W'(TX_LIMIT) + 1'b1, '0);
    offer(KIND_SEND, FRAME_W'(TX_LIMIT), '0);
    offer(~KIND_SEND, '0, '0);
    // Completing an already free head walks the free list until it is full.
    offer(~KIND_SEND, '0, '0);
    offer(~KIND_SEND, '0, '1);
    settle();
    write_reg(REG_QUEUE_ENTRIES, 9'd0);
    offer(KIND_SEND, 16'd7, '0);
    offer(KIND_SEND, 16'd8, '0);
    offer(~KIND_SEND, '0, 8'd200);
    offer(~KIND_SEND, '0, '0);
    settle();
    write_reg(REG_QUEUE_ENTRIES, '1);
    offer(~KIND_SEND, '0, '1);
    offer(KIND_SEND, '1, '0);
    settle();
    write_reg(REG_QUEUE_ENTRIES, 9'd3);
    offer(KIND_SEND, 16'd1, '0);
    offer(KIND_SEND, 16'd2, '0);
    offer(~KIND_SEND, '0, 8'd2);
    settle();
    write_reg(REG_ENABLE, 9'h1FE);
    offer(KIND_SEND, 16'd64, '0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      sz = (p >= 8) ? $urandom_range(0, 511) : sizes[p];
      write_reg(REG_QUEUE_ENTRIES, CFG_DATA_W'(sz));
      write_reg(REG_ENABLE, {8'($urandom), 1'b1});
      tx_gaps = (p % 3 != 1);
      rx_gaps <= (p % 4 != 2);
      if (p == 2) hold_rsp <= 1'b1;
      if (p == 6) begin
        write_reg(REG_ENABLE, {8'($urandom), 1'b0});
        repeat (40) next_word();
        settle();
        write_reg(REG_ENABLE, 9'd1);
      end
      for (int i = 0; i < PHASE_LEN; i++) begin
        // Once, let the block drain completely in the middle of traffic.
        if (p == 4 && i == PHASE_LEN / 2) settle();
        next_word();
      end
    end

    settle();
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_virtqueue_descriptor_free_list: clean");
    end else begin
      $display("tb_virtqueue_descriptor_free_list: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/vqfl_pkg.sv
hw/rtl/vqfl_if.sv
hw/rtl/vqfl_cmd_fifo.sv
hw/rtl/vqfl_front.sv
hw/rtl/vqfl_back.sv
hw/rtl/virtqueue_descriptor_free_list.sv
verif/vqfl_tx_checker.sv
verif/tb_virtqueue_descriptor_free_list.sv
